// ===== rtl/core/wsti_pkg.sv =====
// Shared types and constants for the wide string to int64 converter.
// No dependencies; every other file of the block imports this package.
package wsti_pkg;

	localparam int CH_W    = 21;
	localparam int DIG_W   = 6;
	localparam int RADIX_W = 6;
	localparam int VAL_W   = 64;
	localparam int OFF_W   = 16;

	localparam logic [CH_W-1:0] CH_TAB   = 21'h09;
	localparam logic [CH_W-1:0] CH_CR    = 21'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 21'h20;
	localparam logic [CH_W-1:0] CH_PLUS  = 21'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 21'h2D;
	localparam logic [CH_W-1:0] CH_0     = 21'h30;
	localparam logic [CH_W-1:0] CH_9     = 21'h39;
	localparam logic [CH_W-1:0] CH_UA    = 21'h41;
	localparam logic [CH_W-1:0] CH_UX    = 21'h58;
	localparam logic [CH_W-1:0] CH_UZ    = 21'h5A;
	localparam logic [CH_W-1:0] CH_LA    = 21'h61;
	localparam logic [CH_W-1:0] CH_LX    = 21'h78;
	localparam logic [CH_W-1:0] CH_LZ    = 21'h7A;

	localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIG_W-1:0] DIG_LETTER = 6'd10;

	localparam logic [VAL_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic             is_space;
		logic             is_plus;
		logic             is_minus;
		logic             is_zero;
		logic             is_x;
		logic             dig_ok;
		logic [DIG_W-1:0] dig;
	} char_info_t;

	typedef struct packed {
		logic [VAL_W-1:0] acc;
		logic             ovf;
	} mac_res_t;

endpackage

// ===== rtl/core/wsti_chan_if.sv =====
// Handshake channels of the converter: character items in, result items out.
// Depends on wsti_pkg for field widths.
interface wsti_char_if;
	import wsti_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            start_req;
	modport source (output valid, ch, start_req, input ready);
	modport sink   (input valid, ch, start_req, output ready);
endinterface

interface wsti_result_if;
	import wsti_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    range_error;
	logic                    digits_found;
	logic [OFF_W-1:0]        end_offset;
	modport source (output valid, value, range_error, digits_found, end_offset, input ready);
	modport sink   (input valid, value, range_error, digits_found, end_offset, output ready);
endinterface

// ===== rtl/core/wsti_char_class.sv =====
// Character classifier: white space, sign, prefix characters and digit value.
// Depends on wsti_pkg.
module wsti_char_class (
	input  logic [wsti_pkg::CH_W-1:0] ch,
	output wsti_pkg::char_info_t      info
);
	import wsti_pkg::*;

	always_comb begin
		info          = '0;
		info.is_space = (ch inside {[CH_TAB:CH_CR]}) || (ch == CH_SPACE);
		info.is_plus  = (ch == CH_PLUS);
		info.is_minus = (ch == CH_MINUS);
		info.is_zero  = (ch == CH_0);
		info.is_x     = (ch == CH_LX) || (ch == CH_UX);
		if (ch inside {[CH_0:CH_9]}) begin
			info.dig_ok = 1'b1;
			info.dig    = DIG_W'(ch - CH_0);
		end else if (ch inside {[CH_UA:CH_UZ]}) begin
			info.dig_ok = 1'b1;
			info.dig    = DIG_W'(ch - CH_UA) + DIG_LETTER;
		end else if (ch inside {[CH_LA:CH_LZ]}) begin
			info.dig_ok = 1'b1;
			info.dig    = DIG_W'(ch - CH_LA) + DIG_LETTER;
		end
	end

endmodule

// ===== rtl/core/wsti_mac.sv =====
// Digit accumulate step: acc * base + digit with an exact range test
// against the signed limit of the current sign. Depends on wsti_pkg.
module wsti_mac (
	input  logic [wsti_pkg::VAL_W-1:0]   acc,
	input  logic [wsti_pkg::RADIX_W-1:0] base,
	input  logic [wsti_pkg::DIG_W-1:0]   dig,
	input  logic                         neg,
	output wsti_pkg::mac_res_t           res
);
	import wsti_pkg::*;

	localparam int PROD_W = VAL_W + RADIX_W;
	localparam int SUM_W  = PROD_W + 1;

	logic [RADIX_W-1:0] b;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   limit;

	always_comb begin
		// a zero base reaches here only while no digit is taken; fall back to decimal
		b     = (base == RADIX_AUTO) ? RADIX_DEC : base;
		prod  = PROD_W'(acc) * PROD_W'(b);
		sum   = SUM_W'(prod) + SUM_W'(dig);
		limit = neg ? SUM_W'(INT64_MIN) : SUM_W'(INT64_MAX);
		res.ovf = (sum > limit);
		res.acc = sum[VAL_W-1:0];
	end

endmodule

// ===== rtl/core/wide_string_to_int64.sv =====
// Top level of the wide string to int64 converter: input register, scan state,
// result register. Depends on wsti_pkg, wsti_chan_if, wsti_char_class, wsti_mac.
//
//   port     dir   handshake      payload
//   chars    in    valid/ready    ch[20:0], start_req
//   result   out   valid/ready    value[63:0] signed, range_error, digits_found,
//                                 end_offset[15:0]
//   cfg      in    cfg_we         cfg_wdata[5:0] -> radix (reset 10)
//
// Cycles: one item per clock while the result is not stalled. An accepted item
// is held in the input register, then its character updates the scan state and,
// at the end of a number, loads the result register. The state update (one
// 64 x 6 multiply, add and compare) is combinational, which sets the rate.
// Reset clears the scan state to idle and radix to 10. A stalled result holds
// the input register, and chars.ready drops only when both are full.
module wide_string_to_int64 #(
	parameter int unsigned MAX_OFFSET = 65535
) (
	input  logic                         clk,
	input  logic                         arst_n,
	wsti_char_if.sink                    chars,
	wsti_result_if.source                result,
	input  logic                         cfg_we,
	input  logic [wsti_pkg::RADIX_W-1:0] cfg_wdata
);
	import wsti_pkg::*;

	// offset saturates at the smaller of MAX_OFFSET and the port range
	localparam int unsigned OFF_LIM = (MAX_OFFSET < 32'd65535) ? MAX_OFFSET : 32'd65535;
	localparam int POS_W = $clog2(OFF_LIM + 1);
	localparam logic [POS_W-1:0] POS_LIM = POS_W'(OFF_LIM);

	// scan phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_XSEEN  = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	// configuration
	logic [RADIX_W-1:0] radix_q;

	// input register
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            start_s1;

	// scan state
	logic [2:0]         phase_q;
	logic               neg_q;
	logic [RADIX_W-1:0] base_q;
	logic [VAL_W-1:0]   acc_q;
	logic               ovf_q;
	logic [POS_W-1:0]   pos_q;
	logic               any_q;

	// result register
	logic                    valid_s2;
	logic signed [VAL_W-1:0] value_s2;
	logic                    range_s2;
	logic                    digits_s2;
	logic [OFF_W-1:0]        end_s2;

	logic advance;

	char_info_t info;
	mac_res_t   mac;

	// next-state terms
	logic               live;
	logic [2:0]         ph_cur;
	logic [2:0]         ph_n;
	logic               neg_b;
	logic [VAL_W-1:0]   acc_b;
	logic               ovf_b;
	logic [RADIX_W-1:0] base_n;
	logic               any_n;
	logic [POS_W-1:0]   idx;
	logic [POS_W-1:0]   pos_n;
	logic [POS_W-1:0]   end_idx;
	logic               do_begin;
	logic               do_take;
	logic               do_acc;
	logic               emit;
	logic [RADIX_W-1:0] fixed_radix;
	logic               auto_radix;
	logic [VAL_W-1:0]   acc_n;
	logic               ovf_n;
	logic [VAL_W-1:0]   value_n;

	wsti_char_class u_class (
		.ch   (ch_s1),
		.info (info)
	);

	wsti_mac u_mac (
		.acc  (acc_b),
		.base (base_n),
		.dig  (info.dig),
		.neg  (neg_b),
		.res  (mac)
	);

	// process the held item when the result register can take whatever it makes
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign chars.ready = !valid_s1 || advance;

	assign auto_radix  = (radix_q == RADIX_AUTO);
	assign fixed_radix = (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

	// phase walk: white space, sign, prefix, digits
	always_comb begin
		live   = 1'b1;
		ph_cur = phase_q;
		neg_b  = neg_q;
		acc_b  = acc_q;
		ovf_b  = ovf_q;
		base_n = base_q;
		any_n  = any_q;
		idx    = pos_q;
		if (start_s1) begin
			// a start drops any conversion in flight
			ph_cur = PH_LEAD;
			neg_b  = 1'b0;
			acc_b  = '0;
			ovf_b  = 1'b0;
			base_n = '0;
			any_n  = 1'b0;
			idx    = '0;
		end else if (phase_q == PH_IDLE) begin
			live = 1'b0;
		end
		pos_n    = (idx < POS_LIM) ? idx + POS_W'(1) : POS_LIM;
		ph_n     = ph_cur;
		end_idx  = idx;
		do_begin = 1'b0;
		do_take  = 1'b0;
		do_acc   = 1'b0;
		emit     = 1'b0;
		if (live) begin
			case (ph_cur)
				PH_LEAD: begin
					if (info.is_space) begin
						ph_n = PH_LEAD;
					end else if (info.is_minus) begin
						neg_b = 1'b1;
						ph_n  = PH_SIGNED;
					end else if (info.is_plus) begin
						ph_n = PH_SIGNED;
					end else begin
						do_begin = 1'b1;
					end
				end
				PH_SIGNED: begin
					do_begin = 1'b1;
				end
				PH_ZERO: begin
					if (info.is_x) begin
						base_n = RADIX_HEX;
						ph_n   = PH_XSEEN;
					end else begin
						base_n  = auto_radix ? RADIX_OCT : RADIX_HEX;
						ph_n    = PH_DIGITS;
						do_take = 1'b1;
					end
				end
				PH_XSEEN: begin
					if (info.dig_ok && (info.dig < RADIX_HEX)) begin
						do_acc = 1'b1;
						ph_n   = PH_DIGITS;
					end else begin
						// "0x" with no hex digit: the zero alone was converted
						emit    = 1'b1;
						end_idx = (idx != '0) ? idx - POS_W'(1) : '0;
					end
				end
				PH_DIGITS: begin
					do_take = 1'b1;
				end
				default: begin
					ph_n = PH_IDLE;
				end
			endcase
		end
		if (do_begin) begin
			if ((auto_radix || (radix_q == RADIX_HEX)) && info.is_zero) begin
				any_n = 1'b1;
				ph_n  = PH_ZERO;
			end else begin
				base_n  = auto_radix ? RADIX_DEC : fixed_radix;
				ph_n    = PH_DIGITS;
				do_take = 1'b1;
			end
		end
		if (do_take) begin
			if (info.dig_ok && (info.dig < base_n)) begin
				do_acc = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end
		if (do_acc) begin
			any_n = 1'b1;
		end
		if (emit) begin
			ph_n = PH_IDLE;
		end
	end

	// accumulate, sticky overflow, result value
	always_comb begin
		acc_n = acc_b;
		ovf_n = ovf_b;
		if (do_acc && !ovf_b) begin
			if (mac.ovf) begin
				ovf_n = 1'b1;
			end else begin
				acc_n = mac.acc;
			end
		end
		if (ovf_b) begin
			value_n = neg_b ? INT64_MIN : INT64_MAX;
		end else begin
			value_n = neg_b ? (VAL_W'(0) - acc_b) : acc_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1    <= chars.ch;
			start_s1 <= chars.start_req;
		end
	end

	// scan state: advance once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			any_q   <= 1'b0;
		end else if (advance && live) begin
			phase_q <= ph_n;
			neg_q   <= neg_b;
			base_q  <= base_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			pos_q   <= pos_n;
			any_q   <= any_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_s2  <= value_n;
			range_s2  <= ovf_b;
			digits_s2 <= any_n;
			end_s2    <= any_n ? OFF_W'(end_idx) : '0;
		end
	end

	assign result.valid        = valid_s2;
	assign result.value        = value_s2;
	assign result.range_error  = range_s2;
	assign result.digits_found = digits_s2;
	assign result.end_offset   = end_s2;

endmodule
